@@ rtl/glyph_coverage_blit_top_macros.svh @@
// assertion helpers for the top level rtl, clocked on i_clk, quiet during reset
`ifndef GLYPH_COVERAGE_BLIT_TOP_MACROS_SVH
`define GLYPH_COVERAGE_BLIT_TOP_MACROS_SVH

// same-cycle implication
`define GCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gcb_pkg.sv @@
`timescale 1ns / 1ps

package gcb_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] CFG_SURFACE_PITCH = 3'd2;
    localparam logic [2:0] CFG_ELEMENT_SIZE  = 3'd3;
    localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_GLYPH_ROWS    = 3'd5;
    localparam logic [2:0] CFG_DRAW_COLOR    = 3'd6;
    localparam logic [2:0] CFG_STORE_MODE    = 3'd7;

    // store modes
    localparam logic MODE_OPAQUE = 1'b0;
    localparam logic MODE_ALPHA  = 1'b1;

    // bytes written per pixel in each mode
    localparam logic [2:0] BYTES_OPAQUE = 3'd3;
    localparam logic [2:0] BYTES_ALPHA  = 3'd4;

    // glyph placement and surface geometry
    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [15:0] surface_pitch;
        logic [2:0]  element_size;
        logic [10:0] glyph_width;
        logic [10:0] glyph_rows;
    } t_geom;

    // control from the top level to the address generator
    typedef struct packed {
        logic rearm;
        logic step;
    } t_agen_ctrl;

endpackage

@@ rtl/glyph_coverage_blit_top.sv @@
// glyph coverage blit
//
// Input channel: one coverage byte per item on i_coverage, taken at a clock
// edge with i_in_valid high and o_in_stall low. Bytes come in glyph row order.
// Output channel: one result per input item (offset, write enable, pixel
// bytes, byte count, glyph done), taken when o_out_valid is high and
// i_out_stall is low.
// Configuration: i_cfg_valid/o_cfg_ready write channel, register index on
// i_cfg_index, data on i_cfg_data; o_cfg_ready is always high. Write only
// while no item is in flight. Geometry writes rearm the glyph walk.
// The input stage loads at the accepting edge and the result stage loads from
// it once the result register can advance; o_out_valid rises as it loads.
// Throughput: one item per cycle while the receiver does not stall; the offset
// step and the three 8x8 colour multiplies are combinational.
// Receiver stall: the result register holds; the input stage still fills
// once, then o_in_stall rises until the receiver takes the result.
// Reset (synchronous, active low): pipeline empty, registers at defaults
// (element size 4, width 1, rows 1), walk at the glyph origin.
`timescale 1ns / 1ps
`include "glyph_coverage_blit_top_macros.svh"

module glyph_coverage_blit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // coverage input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_coverage,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pixel_offset,
    output logic        o_write_enable,
    output logic [31:0] o_pixel_bytes,
    output logic [2:0]  o_byte_count,
    output logic        o_glyph_done,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import gcb_pkg::*;

    t_geom       r_geom;
    logic [23:0] r_color;
    logic        r_mode;

    logic        r_s1_valid;
    logic [7:0]  r_s1_coverage;
    logic [31:0] r_s1_offset;
    logic        r_s1_done;

    logic        r_out_valid;
    logic [31:0] r_out_offset;
    logic        r_out_we;
    logic [31:0] r_out_bytes;
    logic [2:0]  r_out_count;
    logic        r_out_done;

    logic        w_cfg_wr;
    logic        w_geom_wr;
    logic        w_out_adv;
    logic        w_in_acc;
    t_agen_ctrl  w_ctrl;
    logic [31:0] w_offset;
    logic        w_done;
    logic [31:0] w_bytes;
    logic        w_we;
    logic [2:0]  w_count;

    // configuration decode
    assign o_cfg_ready = 1'b1;
    always_comb begin
        w_cfg_wr  = i_cfg_valid && o_cfg_ready;
        w_geom_wr = w_cfg_wr && (i_cfg_index inside {[CFG_ORIGIN_X:CFG_GLYPH_ROWS]});
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.origin_x      <= '0;
            r_geom.origin_y      <= '0;
            r_geom.surface_pitch <= '0;
            r_geom.element_size  <= 3'd4;
            r_geom.glyph_width   <= 11'd1;
            r_geom.glyph_rows    <= 11'd1;
            r_color              <= '0;
            r_mode               <= MODE_OPAQUE;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:      r_geom.origin_x      <= i_cfg_data[11:0];
                CFG_ORIGIN_Y:      r_geom.origin_y      <= i_cfg_data[11:0];
                CFG_SURFACE_PITCH: r_geom.surface_pitch <= i_cfg_data[15:0];
                CFG_ELEMENT_SIZE:  r_geom.element_size  <= i_cfg_data[2:0];
                CFG_GLYPH_WIDTH:   r_geom.glyph_width   <= i_cfg_data[10:0];
                CFG_GLYPH_ROWS:    r_geom.glyph_rows    <= i_cfg_data[10:0];
                CFG_DRAW_COLOR:    r_color              <= i_cfg_data[23:0];
                CFG_STORE_MODE:    r_mode               <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    always_comb begin
        w_out_adv   = !r_out_valid || !i_out_stall;
        o_in_stall  = r_s1_valid && !w_out_adv;
        w_in_acc    = i_in_valid && !o_in_stall;
        w_ctrl.rearm = w_geom_wr;
        w_ctrl.step  = w_in_acc;
    end

    gcb_addr_gen u_addr_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (r_geom),
        .i_ctrl   (w_ctrl),
        .o_offset (w_offset),
        .o_done   (w_done)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_coverage <= i_coverage;
            r_s1_offset   <= w_offset;
            r_s1_done     <= w_done;
        end
    end

    gcb_shade u_shade (
        .i_coverage     (r_s1_coverage),
        .i_color        (r_color),
        .i_mode         (r_mode),
        .o_pixel_bytes  (w_bytes),
        .o_write_enable (w_we),
        .o_byte_count   (w_count)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_out_offset <= r_s1_offset;
            r_out_we     <= w_we;
            r_out_bytes  <= w_bytes;
            r_out_count  <= w_count;
            r_out_done   <= r_s1_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_offset = r_out_offset;
    assign o_write_enable = r_out_we;
    assign o_pixel_bytes  = r_out_bytes;
    assign o_byte_count   = r_out_count;
    assign o_glyph_done   = r_out_done;

    // checks on the pipeline and result packing
    `GCB_ASSERT_NEXT(a_s1_kept, r_s1_valid && !w_out_adv, r_s1_valid, "input stage item lost")
    `GCB_ASSERT_NOW(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid, "stall with room")
    `GCB_ASSERT_NOW(a_blank_no_bytes, o_out_valid && !o_write_enable, o_pixel_bytes == 32'd0,
        "bytes on a transparent pixel")
    `GCB_ASSERT_NOW(a_opaque_no_alpha, o_out_valid && o_byte_count == BYTES_OPAQUE,
        o_pixel_bytes[31:24] == 8'd0, "alpha byte set in opaque mode")

endmodule

@@ rtl/gcb_addr_gen.sv @@
`timescale 1ns / 1ps

module gcb_addr_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcb_pkg::t_geom     i_geom,
    input  gcb_pkg::t_agen_ctrl i_ctrl,
    output logic [31:0]        o_offset,
    output logic               o_done
);
    import gcb_pkg::*;

    logic [10:0] r_col;
    logic [10:0] r_row;
    logic [31:0] r_row_start;
    logic [31:0] r_cur;
    logic        r_at_origin;

    logic [27:0] w_oy_prod;
    logic [14:0] w_ox_prod;
    logic [31:0] w_origin;
    logic [31:0] w_row_start;
    logic [31:0] w_cur;
    logic [10:0] w_col_inc;
    logic [10:0] w_row_inc;
    logic        w_row_end;
    logic        w_last_row;

    // glyph origin offset from the current geometry
    always_comb begin
        w_oy_prod = i_geom.origin_y * i_geom.surface_pitch;
        w_ox_prod = i_geom.origin_x * i_geom.element_size;
        w_origin  = {4'd0, w_oy_prod} + {17'd0, w_ox_prod};
    end

    // offsets and row position for the item being taken now
    always_comb begin
        w_row_start = r_at_origin ? w_origin : r_row_start;
        w_cur       = r_at_origin ? w_origin : r_cur;
        w_col_inc   = r_col + 11'd1;
        w_row_inc   = r_row + 11'd1;
        w_row_end   = (w_col_inc == i_geom.glyph_width);
        w_last_row  = (w_row_inc == i_geom.glyph_rows);
    end

    assign o_offset = w_cur;
    assign o_done   = w_row_end && w_last_row;

    // counters and offsets, rearmed to the origin on geometry writes and glyph end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_at_origin <= 1'b1;
        end else if (i_ctrl.rearm) begin
            r_col       <= '0;
            r_row       <= '0;
            r_at_origin <= 1'b1;
        end else if (i_ctrl.step) begin
            if (o_done) begin
                r_col       <= '0;
                r_row       <= '0;
                r_at_origin <= 1'b1;
            end else if (w_row_end) begin
                r_col       <= '0;
                r_row       <= w_row_inc;
                r_row_start <= w_row_start + {16'd0, i_geom.surface_pitch};
                r_cur       <= w_row_start + {16'd0, i_geom.surface_pitch};
                r_at_origin <= 1'b0;
            end else begin
                r_col       <= w_col_inc;
                r_row_start <= w_row_start;
                r_cur       <= w_cur + {29'd0, i_geom.element_size};
                r_at_origin <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/gcb_shade.sv @@
`timescale 1ns / 1ps

module gcb_shade (
    input  logic [7:0]  i_coverage,
    input  logic [23:0] i_color,
    input  logic        i_mode,
    output logic [31:0] o_pixel_bytes,
    output logic        o_write_enable,
    output logic [2:0]  o_byte_count
);
    import gcb_pkg::*;

    // floor(c * v / 255) without a divider: exact for 8-bit operands
    function automatic logic [7:0] modulate(input logic [7:0] c, input logic [7:0] v);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = c * v;
        sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    logic [23:0] w_mod;

    // three colour lanes scaled by coverage
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mod[k*8 +: 8] = modulate(i_color[k*8 +: 8], i_coverage);
        end
    end

    // byte packing per store mode, nothing for transparent coverage
    always_comb begin
        o_write_enable = (i_coverage != 8'd0);
        o_byte_count   = (i_mode == MODE_ALPHA) ? BYTES_ALPHA : BYTES_OPAQUE;
        if (!o_write_enable) begin
            o_pixel_bytes = '0;
        end else if (i_mode == MODE_ALPHA) begin
            o_pixel_bytes = {i_coverage, i_color};
        end else begin
            o_pixel_bytes = {8'd0, w_mod};
        end
    end

endmodule

@@ verif/glyph_coverage_blit_top_tb.sv @@
`timescale 1ns / 1ps

module glyph_coverage_blit_top_tb;
    import gcb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 800;
    localparam int WRAP_ITEMS   = 200;

    // one pixel write as the block reports it
    typedef struct packed {
        logic [31:0] pixel_offset;
        logic        write_enable;
        logic [31:0] pixel_bytes;
        logic [2:0]  byte_count;
        logic        glyph_done;
    } t_pixel_write;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  coverage  = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] pixel_offset;
    logic        write_enable;
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;
    logic        glyph_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data  = 32'd0;

    glyph_coverage_blit_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_coverage     (coverage),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_offset (pixel_offset),
        .o_write_enable (write_enable),
        .o_pixel_bytes  (pixel_bytes),
        .o_byte_count   (byte_count),
        .o_glyph_done   (glyph_done),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted register copy and glyph walk
    t_geom       geom;
    logic [31:0] ink_colour;
    logic        blend_mode;
    logic [10:0] col_idx;
    logic [10:0] row_idx;
    logic [31:0] line_base;
    logic [31:0] pen_offset;

    t_pixel_write expected_pixels[$];
    t_pixel_write want;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // sender and receiver pacing
    int burst_left    = 0;
    int max_gap       = 0;
    int stall_percent = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int stall_run     = 0;

    function automatic logic [31:0] anchor_offset();
        logic [31:0] oy;
        logic [31:0] ox;
        logic [31:0] pitch;
        logic [31:0] esz;
        oy    = 32'(geom.origin_y);
        ox    = 32'(geom.origin_x);
        pitch = 32'(geom.surface_pitch);
        esz   = 32'(geom.element_size);
        return oy * pitch + ox * esz;
    endfunction

    function automatic void rewind_walk();
        col_idx    = '0;
        row_idx    = '0;
        line_base  = anchor_offset();
        pen_offset = line_base;
    endfunction

    function automatic void reset_predictor();
        geom              = '0;
        geom.element_size = 3'd4;
        geom.glyph_width  = 11'd1;
        geom.glyph_rows   = 11'd1;
        ink_colour        = '0;
        blend_mode        = MODE_OPAQUE;
        rewind_walk();
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_ORIGIN_X: begin
                geom.origin_x = data[11:0];
                rewind_walk();
            end
            CFG_ORIGIN_Y: begin
                geom.origin_y = data[11:0];
                rewind_walk();
            end
            CFG_SURFACE_PITCH: begin
                geom.surface_pitch = data[15:0];
                rewind_walk();
            end
            CFG_ELEMENT_SIZE: begin
                geom.element_size = data[2:0];
                rewind_walk();
            end
            CFG_GLYPH_WIDTH: begin
                geom.glyph_width = data[10:0];
                rewind_walk();
            end
            CFG_GLYPH_ROWS: begin
                geom.glyph_rows = data[10:0];
                rewind_walk();
            end
            CFG_DRAW_COLOR: ink_colour = data;
            CFG_STORE_MODE: blend_mode = data[0];
            default: ;
        endcase
    endfunction

    // floor(c * cov / 255)
    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] cov);
        logic [15:0] prod;
        prod = c * cov;
        return 8'(prod / 16'd255);
    endfunction

    // expected write for one coverage byte, then advance the walk
    function automatic t_pixel_write predict_blit(input logic [7:0] cov);
        t_pixel_write px;
        logic [10:0]  next_col;
        logic [10:0]  next_row;
        logic         row_end;
        logic         last_row;
        next_col = col_idx + 11'd1;
        next_row = row_idx + 11'd1;
        row_end  = (next_col == geom.glyph_width);
        last_row = (next_row == geom.glyph_rows);

        px.pixel_offset = pen_offset;
        px.write_enable = (cov != 8'd0);
        px.pixel_bytes  = '0;
        if (cov != 8'd0) begin
            if (blend_mode == MODE_ALPHA) begin
                px.pixel_bytes = {cov, ink_colour[23:0]};
            end else begin
                px.pixel_bytes = {8'd0, scale_channel(ink_colour[23:16], cov),
                                  scale_channel(ink_colour[15:8], cov),
                                  scale_channel(ink_colour[7:0], cov)};
            end
        end
        px.byte_count = (blend_mode == MODE_ALPHA) ? BYTES_ALPHA : BYTES_OPAQUE;
        px.glyph_done = row_end && last_row;

        if (px.glyph_done) begin
            rewind_walk();
        end else if (row_end) begin
            col_idx    = '0;
            row_idx    = next_row;
            line_base  = line_base + 32'(geom.surface_pitch);
            pen_offset = line_base;
        end else begin
            col_idx    = next_col;
            pen_offset = pen_offset + 32'(geom.element_size);
        end
        return px;
    endfunction

    // coverage biased towards transparent and full bytes
    function automatic logic [7:0] rand_coverage();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) return 8'd0;
        if (pick < 35) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic int glyph_items();
        int w;
        int r;
        w = (geom.glyph_width == 11'd0) ? 2048 : int'(geom.glyph_width);
        r = (geom.glyph_rows == 11'd0) ? 2048 : int'(geom.glyph_rows);
        return w * r;
    endfunction

    // one coverage item, with a random gap between bursts
    task automatic send_coverage(input logic [7:0] cov);
        if (burst_left == 0) begin
            if (max_gap != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(max_gap, 1)) @(posedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
        in_valid <= 1'b1;
        coverage <= cov;
        do @(posedge clk); while (in_stall);
        expected_pixels.push_back(predict_blit(cov));
    endtask

    task automatic send_random_bytes(input int count);
        repeat (count) send_coverage(rand_coverage());
    endtask

    // wait until every expected write has come back
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_geometry(input logic [11:0] ox, input logic [11:0] oy,
                                  input logic [15:0] pitch, input logic [2:0] esz,
                                  input logic [10:0] w, input logic [10:0] r);
        write_reg(CFG_ORIGIN_X, 32'(ox));
        write_reg(CFG_ORIGIN_Y, 32'(oy));
        write_reg(CFG_SURFACE_PITCH, 32'(pitch));
        write_reg(CFG_ELEMENT_SIZE, 32'(esz));
        write_reg(CFG_GLYPH_WIDTH, 32'(w));
        write_reg(CFG_GLYPH_ROWS, 32'(r));
    endtask

    // defaults after reset: one-pixel glyph at offset zero, black, opaque
    task automatic test_reset_state();
        stall_percent = 30;
        max_gap = 3;
        send_coverage(8'd0);
        send_coverage(8'hff);
        send_coverage(8'h80);
        drain_pipeline();
    endtask

    // opaque scaling, alpha packing, colour high byte ignored, mode switch between glyphs
    task automatic test_colour_modes();
        write_reg(CFG_DRAW_COLOR, 32'hffff_ffff);
        write_reg(CFG_STORE_MODE, {31'd0, MODE_OPAQUE});
        send_coverage(8'hff);
        send_coverage(8'h01);
        send_coverage(8'h80);
        drain_pipeline();
        write_reg(CFG_DRAW_COLOR, 32'h5a3c_a5f0);
        send_coverage(8'h4d);
        drain_pipeline();
        write_reg(CFG_STORE_MODE, {31'h7fff_ffff, MODE_ALPHA});
        send_coverage(8'd0);
        send_coverage(8'hc8);
        send_coverage(8'hff);
        drain_pipeline();
        write_reg(CFG_DRAW_COLOR, 32'd0);
        send_coverage(8'h7f);
        drain_pipeline();
    endtask

    // largest origin and pitch, odd element sizes, widest and zero-sized glyphs
    task automatic test_geometry_extremes();
        write_geometry(12'd4095, 12'd4095, 16'hffff, 3'd3, 11'd2, 11'd2);
        write_reg(CFG_DRAW_COLOR, 32'h00c0_ffee);
        send_random_bytes(5);
        drain_pipeline();
        write_reg(CFG_GLYPH_WIDTH, 32'd3);
        write_reg(CFG_GLYPH_ROWS, 32'd1);
        write_reg(CFG_ELEMENT_SIZE, 32'd7);
        send_random_bytes(2);
        drain_pipeline();
        write_reg(CFG_ELEMENT_SIZE, 32'd0);
        send_random_bytes(2);
        drain_pipeline();
        write_reg(CFG_ELEMENT_SIZE, 32'd4);
        write_reg(CFG_GLYPH_WIDTH, 32'd1024);
        write_reg(CFG_GLYPH_ROWS, 32'd1024);
        send_random_bytes(2);
        drain_pipeline();
        write_reg(CFG_GLYPH_WIDTH, 32'd0);
        write_reg(CFG_GLYPH_ROWS, 32'd0);
        send_random_bytes(2);
        drain_pipeline();
    endtask

    // geometry writes restart the walk, colour and mode writes do not
    task automatic test_rearm_on_write();
        write_geometry(12'd0, 12'd0, 16'd100, 3'd4, 11'd4, 11'd2);
        write_reg(CFG_STORE_MODE, {31'd0, MODE_OPAQUE});
        send_random_bytes(3);
        drain_pipeline();
        write_reg(CFG_ORIGIN_X, 32'd5);
        send_random_bytes(3);
        drain_pipeline();
        write_reg(CFG_DRAW_COLOR, 32'h0012_3456);
        send_random_bytes(2);
        drain_pipeline();
        write_reg(CFG_STORE_MODE, {31'd0, MODE_ALPHA});
        send_random_bytes(4);
        drain_pipeline();
    endtask

    // zero width or zero rows must not end a row or the glyph early
    task automatic test_counter_wrap();
        max_gap = 0;
        stall_percent = 10;
        write_geometry(12'd1, 12'd2, 16'd64, 3'd4, 11'd0, 11'd1);
        send_random_bytes(WRAP_ITEMS);
        drain_pipeline();
        write_reg(CFG_GLYPH_WIDTH, 32'd1);
        write_reg(CFG_GLYPH_ROWS, 32'd0);
        send_random_bytes(WRAP_ITEMS);
        drain_pipeline();
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_back_pressure();
        max_gap = 0;
        stall_percent = 0;
        write_geometry(12'd7, 12'd9, 16'd320, 3'd3, 11'd8, 11'd4);
        hold_requests++;
        send_random_bytes(40);
        drain_pipeline();
    endtask

    // mostly whole small glyphs with random content, some noisy settings
    task automatic test_random_glyphs();
        int random_sent;
        int n_glyphs;
        int n_items;
        int split;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain_pipeline();
            case ($urandom_range(2))
                0: max_gap = 0;
                1: max_gap = 2;
                default: max_gap = 8;
            endcase
            case ($urandom_range(2))
                0: stall_percent = 0;
                1: stall_percent = 30;
                default: stall_percent = 60;
            endcase
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(9) < 7) write_reg(CFG_ORIGIN_X, $urandom_range(4095));
                if ($urandom_range(9) < 7) write_reg(CFG_ORIGIN_Y, $urandom_range(4095));
                if ($urandom_range(9) < 7) write_reg(CFG_SURFACE_PITCH, $urandom_range(65535));
                if ($urandom_range(9) < 2) begin
                    write_reg(CFG_ELEMENT_SIZE, $urandom_range(7));
                end else begin
                    write_reg(CFG_ELEMENT_SIZE, $urandom_range(4, 3));
                end
                write_reg(CFG_GLYPH_WIDTH, $urandom_range(8, 1));
                write_reg(CFG_GLYPH_ROWS, $urandom_range(5, 1));
                if ($urandom_range(9) < 7) write_reg(CFG_DRAW_COLOR, $urandom);
                if ($urandom_range(9) < 7) write_reg(CFG_STORE_MODE, $urandom);
                n_glyphs = $urandom_range(4, 1);
                repeat (n_glyphs) begin
                    n_items = glyph_items();
                    if ($urandom_range(9) < 2) begin
                        // change the colour or mode part way through the glyph
                        split = $urandom_range(n_items);
                        send_random_bytes(split);
                        drain_pipeline();
                        if ($urandom_range(1)) write_reg(CFG_DRAW_COLOR, $urandom);
                        else write_reg(CFG_STORE_MODE, $urandom);
                        send_random_bytes(n_items - split);
                    end else begin
                        send_random_bytes(n_items);
                    end
                    random_sent += n_items;
                end
            end else begin
                // raw register data, only the start of the glyph is walked
                write_reg(CFG_ORIGIN_X, $urandom);
                write_reg(CFG_ORIGIN_Y, $urandom);
                write_reg(CFG_SURFACE_PITCH, $urandom);
                write_reg(CFG_ELEMENT_SIZE, $urandom);
                write_reg(CFG_GLYPH_WIDTH, $urandom);
                write_reg(CFG_GLYPH_ROWS, $urandom);
                write_reg(CFG_DRAW_COLOR, $urandom);
                write_reg(CFG_STORE_MODE, $urandom);
                n_items = $urandom_range(12, 1);
                send_random_bytes(n_items);
                random_sent += n_items;
            end
        end
        drain_pipeline();
    endtask

    // receiver stall pattern, with the long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            stall_run <= 0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            out_stall    <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (stall_percent != 0 && $urandom_range(99) < stall_percent) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(6);
        end else begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(10);
        end
    end

    // compare each accepted result with the oldest expected write
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result, pixel_offset %h", pixel_offset);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (pixel_offset !== want.pixel_offset) begin
                    $error("pixel_offset: expected %h, actual %h",
                           want.pixel_offset, pixel_offset);
                    mismatch_count++;
                end
                if (write_enable !== want.write_enable) begin
                    $error("write_enable: expected %b, actual %b",
                           want.write_enable, write_enable);
                    mismatch_count++;
                end
                if (pixel_bytes !== want.pixel_bytes) begin
                    $error("pixel_bytes: expected %h, actual %h",
                           want.pixel_bytes, pixel_bytes);
                    mismatch_count++;
                end
                if (byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, actual %0d",
                           want.byte_count, byte_count);
                    mismatch_count++;
                end
                if (glyph_done !== want.glyph_done) begin
                    $error("glyph_done: expected %b, actual %b",
                           want.glyph_done, glyph_done);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_colour_modes();
        test_geometry_extremes();
        test_rearm_on_write();
        test_counter_wrap();
        test_back_pressure();
        test_random_glyphs();

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
